// ===== hdl/wlrr_pkg.sv =====
// wlrr_pkg: shared types and constants for the wear-levelled record ring
// holds the slot layout, the transfer payload structs and the operation codes
// no dependencies

package wlrr_pkg;

  localparam int unsigned SLOTS_DEFAULT = 64;
  localparam logic [15:0] SIGNATURE_RESET = 16'hA5A5;

  localparam logic [1:0] MODE_RECOVER = 2'd0;
  localparam logic [1:0] MODE_PUT     = 2'd1;
  localparam logic [1:0] MODE_GET     = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] read_data;
    logic [5:0]  next_slot;
  } out_item_t;

  typedef struct packed {
    logic [15:0] mark;
    logic [15:0] sequence_count;
    logic [31:0] payload;
  } slot_t;

endpackage

// ===== hdl/wlrr_slot_store.sv =====
// wlrr_slot_store: slot memory of the record ring, one read and one write port
// read data is registered; a clearing sweep runs after reset
// depends on wlrr_pkg

module wlrr_slot_store #(
  parameter int unsigned SLOTS = wlrr_pkg::SLOTS_DEFAULT,
  parameter int unsigned AW    = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output wlrr_pkg::slot_t       rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  wlrr_pkg::slot_t       wr_data,
  output logic                  clearing
);

  wlrr_pkg::slot_t mem [SLOTS];

  logic [AW-1:0] clr_addr;

  // erase sweep, one slot a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/wear_levelled_record_ring_top.sv =====
// wear_levelled_record_ring_top: record ring with put, get and recover scan
// depends on wlrr_pkg and wlrr_slot_store

// A ring of SLOTS records (mark, 16-bit sequence count, 32-bit data) held in
// one synchronous memory, plus a write pointer. A put or a get first reads
// the slot before the pointer, then checks it and, for a put, writes the new
// record at the pointer. A recover scan reads slot 0 and then one slot a
// cycle while the chain holds. One item is worked at a time, and a result
// may wait in the output register while the next item is taken. After reset
// a clearing pass erases the memory, during which no item is taken; the
// signature register can be written at any time the block is idle.

module wear_levelled_record_ring_top #(
  parameter int unsigned SLOTS = wlrr_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wlrr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output wlrr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t              state;
  logic [15:0]         signature;
  logic [AW-1:0]       ptr;
  logic [AW-1:0]       scan_idx;
  logic [15:0]         prev_seq;
  logic [1:0]          mode_q;
  logic [31:0]         data_q;
  wlrr_pkg::out_item_t hold_res;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  wlrr_pkg::slot_t     rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  wlrr_pkg::slot_t     wr_data;
  logic                clearing;

  logic                in_take;
  logic                out_free;
  logic                out_load;
  logic                done;
  logic                scan_start;
  logic                scan_step;
  logic                marked;
  logic [AW-1:0]       prev_addr;
  logic [AW-1:0]       ptr_adv;
  logic [AW-1:0]       ptr_next;
  logic [7:0]          seq_diff;
  logic [AW+5:0]       slot_ext;
  wlrr_pkg::out_item_t res;

  wlrr_slot_store #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  assign in_stall  = clearing || (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (done || state == ST_HOLD) && out_free;
  assign cfg_ready = 1'b1;

  assign prev_addr = (ptr == '0) ? LAST_SLOT : ptr - 1'b1;
  assign ptr_adv   = (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
  assign marked    = (rd_data.mark == signature);
  assign seq_diff  = rd_data.sequence_count[7:0] - prev_seq[7:0];

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = ptr;
    wr_data    = '0;
    done       = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    ptr_next   = ptr;
    res        = '0;
    res.status = wlrr_pkg::STATUS_OK;

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          rd_en   = 1'b1;
          rd_addr = (in_item.mode == wlrr_pkg::MODE_RECOVER) ? '0 : prev_addr;
        end
      end
      ST_RD: begin
        case (mode_q)
          wlrr_pkg::MODE_RECOVER: begin
            if (!marked) begin
              ptr_next   = '0;
              res.status = wlrr_pkg::STATUS_FAIL;
              done       = 1'b1;
            end else begin
              scan_start = 1'b1;
              rd_en      = 1'b1;
              rd_addr    = AW'(1);
            end
          end
          wlrr_pkg::MODE_PUT: begin
            wr_en                  = 1'b1;
            wr_data.mark           = signature;
            wr_data.sequence_count = marked ? rd_data.sequence_count + 16'd1 : 16'd0;
            wr_data.payload        = data_q;
            ptr_next               = ptr_adv;
            done                   = 1'b1;
          end
          wlrr_pkg::MODE_GET: begin
            if (marked) begin
              res.read_data = rd_data.payload;
            end else begin
              res.status = wlrr_pkg::STATUS_FAIL;
            end
            done = 1'b1;
          end
          default: begin
            res.status = wlrr_pkg::STATUS_FAIL;
            done       = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        if (!marked || seq_diff != 8'd1) begin
          // chain breaks here, pointer lands on this slot
          ptr_next = scan_idx;
          done     = 1'b1;
        end else if (scan_idx == LAST_SLOT) begin
          ptr_next = '0;
          done     = 1'b1;
        end else begin
          scan_step = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = scan_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase

    slot_ext      = (AW + 6)'(ptr_next);
    res.next_slot = slot_ext[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      signature <= wlrr_pkg::SIGNATURE_RESET;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        signature <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      ptr <= ptr_next;

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_RD;
          end
        end
        ST_RD, ST_SCAN: begin
          if (scan_start || scan_step) begin
            state <= ST_SCAN;
          end else if (done) begin
            if (out_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload, scan and result registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_q <= in_item.mode;
      data_q <= in_item.write_data;
    end
    if (scan_start) begin
      scan_idx <= AW'(1);
      prev_seq <= rd_data.sequence_count;
    end else if (scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      prev_seq <= rd_data.sequence_count;
    end
    if (done) begin
      hold_res <= res;
    end
    if (done && out_free) begin
      out_item <= res;
    end else if (state == ST_HOLD && out_free) begin
      out_item <= hold_res;
    end
  end

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= LAST_SLOT)
    else $error("write pointer beyond the ring");

  a_write_only_in_check: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_RD && mode_q == wlrr_pkg::MODE_PUT && !clearing))
    else $error("slot write outside a put");

  a_read_then_use: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == ST_RD || state == ST_SCAN))
    else $error("memory read not followed by a check cycle");

  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("result held back with the output register empty");

endmodule
